### rtl/sfp_pkg.sv
// shared types and constants of the sparse fan-out propagation block
// used by every module of the block but sfp_ram and sfp_checker; depends on nothing
`default_nettype none
package sfp_pkg;

    localparam int MAX_CONCEPTS = 256;
    localparam int LANES        = 16;
    localparam int CONCEPT_W    = 8;
    localparam int LANE_W       = 4;
    localparam int WEIGHT_W     = 8;
    localparam int AMP_W        = 32;
    localparam int SLOT_W       = CONCEPT_W + LANE_W;
    localparam int CNT_W        = 9;
    localparam int PROD_W       = AMP_W + WEIGHT_W;
    localparam int IN_TDATA_W   = 64;
    localparam int OUT_TDATA_W  = 40;
    localparam int Q_DEPTH      = 2;
    localparam logic [CNT_W-1:0] CFG_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_WR_BRANCH = 2'd0,
        OP_WR_AMP    = 2'd1,
        OP_STEP      = 2'd2,
        OP_RD_AMP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_WR_BRANCH = 3'd0,
        K_WR_AMP    = 3'd1,
        K_STEP      = 3'd2,
        K_RD_AMP    = 3'd3,
        K_REJECT    = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [CONCEPT_W-1:0]  concept;
        logic [LANE_W-1:0]     lane;
        logic [CONCEPT_W-1:0]  target;
        logic [WEIGHT_W-1:0]   weight;
        logic [AMP_W-1:0]      amp;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage
`default_nettype wire

### rtl/sparse_fanout_propagation.sv
// sparse fan-out propagation block
// input stream s_axis: tuser = op, tdata = request fields; output stream m_axis: one
// result per request. config: one write-only register (active_concepts).
// writes: one request per cycle sustained while the receiver takes every result
// reads: the engine takes no new request until the registered amplitude read returns
// step: for n active concepts, each source amplitude is read (S_SRC, S_SRCW); a nonzero
// source then visits each branch lane: a dropped or zero-weight branch passes S_BR and
// S_BRW, a live one also S_DIV and S_ACC (table read, multiply, divide by 255,
// read-add-write of the next amplitude); then each concept is copied to the new
// vector (S_COPY, S_COPYW). the single step sequencer and its ram ports pace the step.
// a two-entry request queue lets requests be accepted while the engine is busy
// or a result waits on a stalled receiver; when the queue is full tready drops.
// reset: active_concepts returns to 256, and a clearing pass over every slot zeroes
// the weight table and the amplitude stores; tready stays low during that pass.
// a stalled result holds in the output register until taken.
// depends on sfp_pkg, sfp_front, sfp_queue, sfp_back, sfp_ram
`default_nettype none
module sparse_fanout_propagation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [8:0]  i_cfg_wdata,     // active_concepts
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // concept[7:0], lane[11:8], branch_target[19:12], branch_weight[27:20],
    // amplitude_in[59:28], zero[63:60]
    input  wire logic [63:0] i_s_axis_tdata,
    input  wire logic [1:0]  i_s_axis_tuser,  // op[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // amplitude_out[31:0], status[32], saturated[33], zero[39:34]
    output logic [39:0]      o_m_axis_tdata
);

    logic [sfp_pkg::CNT_W-1:0] r_active, n_count;
    sfp_pkg::t_cmd      f_cmd, q_cmd;
    sfp_pkg::t_back_stat bstat;
    logic f_push, q_full, q_valid, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= sfp_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    assign n_count = (r_active > sfp_pkg::CNT_W'(sfp_pkg::MAX_CONCEPTS))
                   ? sfp_pkg::CNT_W'(sfp_pkg::MAX_CONCEPTS) : r_active;

    sfp_front u_front (
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata), .i_s_axis_tuser(i_s_axis_tuser),
        .i_n(n_count), .i_bstat(bstat), .i_q_full(q_full),
        .o_push(f_push), .o_cmd(f_cmd)
    );

    sfp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(f_push), .i_cmd(f_cmd),
        .o_full(q_full), .o_valid(q_valid), .o_cmd(q_cmd), .i_pop(q_pop)
    );

    sfp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_n(n_count),
        .i_q_valid(q_valid), .i_q_cmd(q_cmd), .o_q_pop(q_pop), .o_stat(bstat),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata)
    );

endmodule
`default_nettype wire

### rtl/sfp_ram.sv
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none
module sfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/sfp_front.sv
// front end: accepts input requests, range checks and classifies them
// depends on sfp_pkg
`default_nettype none
module sfp_front (
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [sfp_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  wire logic [1:0]                        i_s_axis_tuser,
    input  wire logic [sfp_pkg::CNT_W-1:0]         i_n,
    input  wire sfp_pkg::t_back_stat               i_bstat,
    input  wire logic                              i_q_full,
    output logic                                   o_push,
    output sfp_pkg::t_cmd                          o_cmd
);

    sfp_pkg::t_op op;
    logic         in_range;

    assign op              = sfp_pkg::t_op'(i_s_axis_tuser);
    assign o_s_axis_tready = !i_q_full && !i_bstat.clearing;
    assign o_push          = i_s_axis_tvalid && o_s_axis_tready;

    assign in_range = {1'b0, i_s_axis_tdata[7:0]} < i_n;

    always_comb begin
        o_cmd.concept = i_s_axis_tdata[7:0];
        o_cmd.lane    = i_s_axis_tdata[11:8];
        o_cmd.target  = i_s_axis_tdata[19:12];
        o_cmd.weight  = i_s_axis_tdata[27:20];
        o_cmd.amp     = i_s_axis_tdata[59:28];
        if (op == sfp_pkg::OP_STEP) begin
            o_cmd.kind = sfp_pkg::K_STEP;
        end else if (!in_range) begin
            o_cmd.kind = sfp_pkg::K_REJECT;
        end else begin
            unique case (op)
                sfp_pkg::OP_WR_BRANCH: o_cmd.kind = sfp_pkg::K_WR_BRANCH;
                sfp_pkg::OP_WR_AMP:    o_cmd.kind = sfp_pkg::K_WR_AMP;
                sfp_pkg::OP_RD_AMP:    o_cmd.kind = sfp_pkg::K_RD_AMP;
                default:               o_cmd.kind = sfp_pkg::K_STEP;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/sfp_queue.sv
// short request queue between front end and execution engine
// depends on sfp_pkg
`default_nettype none
module sfp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sfp_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output sfp_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);

    localparam int PW = (sfp_pkg::Q_DEPTH > 1) ? $clog2(sfp_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(sfp_pkg::Q_DEPTH + 1);

    sfp_pkg::t_cmd r_buf [sfp_pkg::Q_DEPTH];
    logic [PW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = r_cnt == CW'(sfp_pkg::Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_buf[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(sfp_pkg::Q_DEPTH - 1)) ? '0 : PW'(r_wp + 1'b1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(sfp_pkg::Q_DEPTH - 1)) ? '0 : PW'(r_rp + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_cnt = CW'(r_cnt + 1'b1);
        end else if (!i_push && i_pop) begin
            n_cnt = CW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_buf[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

### rtl/sfp_back.sv
// execution engine: table and amplitude stores, propagation step sequencer,
// result register; depends on sfp_pkg and sfp_ram
`default_nettype none
module sfp_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [sfp_pkg::CNT_W-1:0]         i_n,
    input  wire logic                              i_q_valid,
    input  wire sfp_pkg::t_cmd                     i_q_cmd,
    output logic                                   o_q_pop,
    output sfp_pkg::t_back_stat                    o_stat,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [sfp_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata
);

    localparam int AW  = sfp_pkg::AMP_W;
    localparam int CW  = sfp_pkg::CONCEPT_W;
    localparam int SW  = sfp_pkg::SLOT_W;
    localparam int NW  = sfp_pkg::CNT_W;
    localparam int PW  = sfp_pkg::PROD_W;
    localparam int RW  = 11;
    localparam int NC  = sfp_pkg::MAX_CONCEPTS;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_RDW   = 11'b00000000100,
        S_SRC   = 11'b00000001000,
        S_SRCW  = 11'b00000010000,
        S_BR    = 11'b00000100000,
        S_BRW   = 11'b00001000000,
        S_DIV   = 11'b00010000000,
        S_ACC   = 11'b00100000000,
        S_COPY  = 11'b01000000000,
        S_COPYW = 11'b10000000000
    } t_state;

    function automatic logic [sfp_pkg::OUT_TDATA_W-1:0] pack_res(
        input logic [AW-1:0] amp, input logic status, input logic sat);
        pack_res = {6'b0, sat, status, amp};
    endfunction

    t_state r_state, n_state;
    logic [SW-1:0] r_idx, n_idx;
    logic [NW-1:0] r_src, n_src, r_cidx, n_cidx;
    logic [sfp_pkg::LANE_W-1:0] r_lane, n_lane;
    logic [AW-1:0] r_amp, n_amp, r_est, n_est, r_nxt, n_nxt;
    logic [PW-1:0] r_prod, n_prod;
    logic [CW-1:0] r_dst, n_dst;
    logic [RW-1:0] r_rem, n_rem;
    logic r_sat, n_sat;
    logic r_out_valid, n_out_valid;
    logic [sfp_pkg::OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // ram ports
    logic          amp_we, nxt_we, tw_we, wgt_we;
    logic [CW-1:0] amp_waddr, amp_raddr, nxt_waddr, nxt_raddr;
    logic [AW-1:0] amp_wdata, amp_rdata, nxt_wdata, nxt_rdata;
    logic [SW-1:0] tw_waddr, tw_raddr, wgt_waddr;
    logic [7:0]    tgt_wdata, tgt_rdata, wgt_wdata, wgt_rdata;

    logic          pop;
    logic [AW-1:0] src_amp, share;
    logic [AW:0]   sum;
    logic [AW-1:0] est_c;
    logic [PW-1:0] rem_full;
    logic [RW-1:0] rem_c;
    logic [2:0]    corr;
    logic          last_src, last_lane;

    assign pop = (r_state == S_IDLE) && i_q_valid && (!r_out_valid || i_m_axis_tready);
    assign o_q_pop         = pop;
    assign o_stat.clearing = r_state == S_CLEAR;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign last_src  = NW'(r_src + 1'b1) >= i_n;
    assign last_lane = r_lane == sfp_pkg::LANE_W'(sfp_pkg::LANES - 1);
    assign src_amp   = amp_rdata;

    // floor(p/255) estimate from the sum of byte shifts, short of the true
    // quotient by at most five
    assign est_c = AW'(r_prod[PW-1:8]) + AW'(r_prod[PW-1:16])
                 + AW'(r_prod[PW-1:24]) + AW'(r_prod[PW-1:32]);
    assign rem_full = r_prod - (({8'b0, est_c} << 8) - {8'b0, est_c});
    assign rem_c    = rem_full[RW-1:0];

    always_comb begin
        logic [RW-1:0] rr;
        rr   = r_rem;
        corr = '0;
        for (int i = 0; i < 6; i++) begin
            if (rr >= RW'(255)) begin
                rr   = RW'(rr - RW'(255));
                corr = 3'(corr + 1'b1);
            end
        end
    end

    assign share = AW'(r_est + AW'(corr));
    assign sum   = {1'b0, r_nxt} + {1'b0, share};

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_src       = r_src;
        n_cidx      = r_cidx;
        n_lane      = r_lane;
        n_amp       = r_amp;
        n_est       = r_est;
        n_nxt       = r_nxt;
        n_prod      = r_prod;
        n_dst       = r_dst;
        n_rem       = r_rem;
        n_sat       = r_sat;
        n_out_valid = (r_out_valid && i_m_axis_tready) ? 1'b0 : r_out_valid;
        n_out_data  = r_out_data;

        amp_we    = 1'b0;
        amp_waddr = i_q_cmd.concept;
        amp_wdata = i_q_cmd.amp;
        amp_raddr = r_src[CW-1:0];
        nxt_we    = 1'b0;
        nxt_waddr = r_dst;
        nxt_wdata = sum[AW] ? '1 : sum[AW-1:0];
        nxt_raddr = r_dst;
        tw_we     = 1'b0;
        tw_waddr  = {i_q_cmd.concept, i_q_cmd.lane};
        tw_raddr  = {r_src[CW-1:0], r_lane};
        tgt_wdata = i_q_cmd.target;
        wgt_we    = 1'b0;
        wgt_waddr = {i_q_cmd.concept, i_q_cmd.lane};
        wgt_wdata = i_q_cmd.weight;

        unique case (r_state)
            S_CLEAR: begin
                // the amplitude stores are cleared alongside the weight table
                wgt_we    = 1'b1;
                wgt_waddr = r_idx;
                wgt_wdata = '0;
                amp_we    = 1'b1;
                amp_waddr = r_idx[CW-1:0];
                amp_wdata = '0;
                nxt_we    = 1'b1;
                nxt_waddr = r_idx[CW-1:0];
                nxt_wdata = '0;
                n_idx     = SW'(r_idx + 1'b1);
                if (r_idx == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (pop) begin
                    unique case (i_q_cmd.kind)
                        sfp_pkg::K_WR_BRANCH: begin
                            tw_we       = 1'b1;
                            wgt_we      = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_data  = pack_res('0, 1'b0, 1'b0);
                        end
                        sfp_pkg::K_WR_AMP: begin
                            amp_we      = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_data  = pack_res('0, 1'b0, 1'b0);
                        end
                        sfp_pkg::K_RD_AMP: begin
                            amp_raddr = i_q_cmd.concept;
                            n_state   = S_RDW;
                        end
                        sfp_pkg::K_STEP: begin
                            n_sat     = 1'b0;
                            n_src     = '0;
                            if (i_n == '0) begin
                                n_out_valid = 1'b1;
                                n_out_data  = pack_res('0, 1'b0, 1'b0);
                            end else begin
                                n_state = S_SRC;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_data  = pack_res('0, 1'b1, 1'b0);
                        end
                    endcase
                end
            end
            S_RDW: begin
                n_out_valid = 1'b1;
                n_out_data  = pack_res(amp_rdata, 1'b0, 1'b0);
                n_state     = S_IDLE;
            end
            S_SRC: begin
                n_state = S_SRCW;
            end
            S_SRCW: begin
                if (src_amp == '0) begin
                    if (last_src) begin
                        n_cidx  = '0;
                        n_state = S_COPY;
                    end else begin
                        n_src   = NW'(r_src + 1'b1);
                        n_state = S_SRC;
                    end
                end else begin
                    n_amp   = src_amp;
                    n_lane  = '0;
                    n_state = S_BR;
                end
            end
            S_BR: begin
                n_state = S_BRW;
            end
            S_BRW: begin
                nxt_raddr = tgt_rdata;
                if (({1'b0, tgt_rdata} >= i_n) || (wgt_rdata == '0)) begin
                    // dropped branch or nothing to add
                    if (!last_lane) begin
                        n_lane  = sfp_pkg::LANE_W'(r_lane + 1'b1);
                        n_state = S_BR;
                    end else if (last_src) begin
                        n_cidx  = '0;
                        n_state = S_COPY;
                    end else begin
                        n_src   = NW'(r_src + 1'b1);
                        n_state = S_SRC;
                    end
                end else begin
                    n_prod  = {8'b0, r_amp} * {32'b0, wgt_rdata};
                    n_dst   = tgt_rdata;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_nxt   = nxt_rdata;
                n_est   = est_c;
                n_rem   = rem_c;
                n_state = S_ACC;
            end
            S_ACC: begin
                nxt_we = 1'b1;
                n_sat  = r_sat | sum[AW];
                if (!last_lane) begin
                    n_lane  = sfp_pkg::LANE_W'(r_lane + 1'b1);
                    n_state = S_BR;
                end else if (last_src) begin
                    n_cidx  = '0;
                    n_state = S_COPY;
                end else begin
                    n_src   = NW'(r_src + 1'b1);
                    n_state = S_SRC;
                end
            end
            S_COPY: begin
                nxt_raddr = r_cidx[CW-1:0];
                n_state   = S_COPYW;
            end
            S_COPYW: begin
                // move the entry and leave the next-amplitude store zeroed
                amp_we    = 1'b1;
                amp_waddr = r_cidx[CW-1:0];
                amp_wdata = nxt_rdata;
                nxt_we    = 1'b1;
                nxt_waddr = r_cidx[CW-1:0];
                nxt_wdata = '0;
                if (NW'(r_cidx + 1'b1) >= i_n) begin
                    n_out_valid = 1'b1;
                    n_out_data  = pack_res('0, 1'b0, r_sat);
                    n_state     = S_IDLE;
                end else begin
                    n_cidx  = NW'(r_cidx + 1'b1);
                    n_state = S_COPY;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_src       <= '0;
            r_cidx      <= '0;
            r_lane      <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_src       <= n_src;
            r_cidx      <= n_cidx;
            r_lane      <= n_lane;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
        end
        r_amp      <= n_amp;
        r_est      <= n_est;
        r_nxt      <= n_nxt;
        r_prod     <= n_prod;
        r_dst      <= n_dst;
        r_rem      <= n_rem;
        r_out_data <= n_out_data;
    end

    sfp_ram #(.WIDTH(AW), .DEPTH(NC)) u_amp_ram (
        .i_clk(i_clk), .i_we(amp_we), .i_waddr(amp_waddr), .i_wdata(amp_wdata),
        .i_raddr(amp_raddr), .o_rdata(amp_rdata)
    );

    sfp_ram #(.WIDTH(AW), .DEPTH(NC)) u_nxt_ram (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_waddr), .i_wdata(nxt_wdata),
        .i_raddr(nxt_raddr), .o_rdata(nxt_rdata)
    );

    sfp_ram #(.WIDTH(8), .DEPTH(NC * sfp_pkg::LANES)) u_tgt_ram (
        .i_clk(i_clk), .i_we(tw_we), .i_waddr(tw_waddr), .i_wdata(tgt_wdata),
        .i_raddr(tw_raddr), .o_rdata(tgt_rdata)
    );

    sfp_ram #(.WIDTH(8), .DEPTH(NC * sfp_pkg::LANES)) u_wgt_ram (
        .i_clk(i_clk), .i_we(wgt_we), .i_waddr(wgt_waddr), .i_wdata(wgt_wdata),
        .i_raddr(tw_raddr), .o_rdata(wgt_rdata)
    );

endmodule
`default_nettype wire

### rtl/sfp_checker.sv
// port level checks of the sparse fan-out propagation block, bound to the top level
// depends on sparse_fanout_propagation ports only
`default_nettype none
module sfp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cfg_we,
    input wire logic [8:0]  i_cfg_wdata,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [63:0] i_s_axis_tdata,
    input wire logic [1:0]  i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // a result with the saturated flag, which only a step sets, carries no amplitude and no status
    a_sat_only_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[33]
        |-> (o_m_axis_tdata[31:0] == 32'd0) && !o_m_axis_tdata[32])
        else $error("saturated flag on a non-step result");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[32] |-> o_m_axis_tdata[31:0] == 32'd0)
        else $error("rejected request returned an amplitude");

    // clearing pass after reset blocks requests
    a_clear_pass: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("request accepted right after reset");

endmodule

bind sparse_fanout_propagation sfp_checker u_sfp_checker (.*);
`default_nettype wire

### dv/tb_top.sv
// testbench for sparse_fanout_propagation: directed and random requests with an
// in-bench predictor of the branch tables and amplitude vector; depends on sfp_pkg
`timescale 1ns / 1ps
module tb_top;

    typedef struct {
        logic [31:0] amp;
        logic        status;
        logic        sat;
    } t_outcome;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int NCPT        = sfp_pkg::MAX_CONCEPTS;
    localparam int NLANE       = sfp_pkg::LANES;
    // in the random tests only concepts below this bound hold a nonzero amplitude
    localparam int LIVE_SET    = 4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [8:0]  i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b1;
    logic [39:0] o_m_axis_tdata;

    sparse_fanout_propagation dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // shadow copy of the block state
    logic [7:0]  branch_dst [NCPT*NLANE];
    logic [7:0]  branch_wgt [NCPT*NLANE];
    bit          branch_set [NCPT*NLANE];
    logic [31:0] amp_vec [NCPT];
    logic [8:0]  active_cnt;
    t_outcome    pending_results[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    longint      cycle_count = 0;

    function automatic int live_count();
        return (active_cnt > NCPT) ? NCPT : int'(active_cnt);
    endfunction

    function automatic logic propagate(int n);
        logic [63:0] nxt [NCPT];
        logic [63:0] share;
        logic [63:0] sum;
        int          slot;
        logic        clipped;
        clipped = 1'b0;
        foreach (nxt[i]) nxt[i] = '0;
        for (int src = 0; src < n; src++) begin
            if (amp_vec[src] != 0) begin
                for (int k = 0; k < NLANE; k++) begin
                    slot = src * NLANE + k;
                    if (branch_dst[slot] < n) begin
                        share = (64'(amp_vec[src]) * 64'(branch_wgt[slot])) / 64'd255;
                        sum = nxt[branch_dst[slot]] + share;
                        if (sum > 64'hFFFF_FFFF) begin
                            sum = 64'hFFFF_FFFF;
                            clipped = 1'b1;
                        end
                        nxt[branch_dst[slot]] = sum;
                    end
                end
            end
        end
        for (int src = 0; src < n; src++) amp_vec[src] = nxt[src][31:0];
        return clipped;
    endfunction

    function automatic t_outcome predict_request(sfp_pkg::t_op op, logic [7:0] cpt,
                                                 logic [3:0] ln, logic [7:0] dst,
                                                 logic [7:0] wgt, logic [31:0] amp);
        t_outcome r;
        int       n;
        n = live_count();
        r = '{amp: '0, status: 1'b0, sat: 1'b0};
        if (op == sfp_pkg::OP_STEP) begin
            r.sat = propagate(n);
        end else if (cpt >= n) begin
            r.status = 1'b1;
        end else if (op == sfp_pkg::OP_WR_BRANCH) begin
            branch_dst[{cpt, ln}] = dst;
            branch_wgt[{cpt, ln}] = wgt;
            branch_set[{cpt, ln}] = 1'b1;
        end else if (op == sfp_pkg::OP_WR_AMP) begin
            amp_vec[cpt] = amp;
        end else begin
            r.amp = amp_vec[cpt];
        end
        return r;
    endfunction

    task automatic send_request(sfp_pkg::t_op op, logic [7:0] cpt, logic [3:0] ln,
                                logic [7:0] dst, logic [7:0] wgt, logic [31:0] amp);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = op;
        i_s_axis_tdata  = {4'b0, amp, wgt, dst, ln, cpt};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(predict_request(op, cpt, ln, dst, wgt, amp));
    endtask

    task automatic write_active_count(logic [8:0] value);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        active_cnt  = value;
    endtask

    function automatic logic [7:0] pick_concept();
        return ($urandom_range(3) != 0) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
    endfunction

    // branch targets stay in the live set so few lanes ever need filling
    function automatic logic [7:0] pick_live();
        return 8'($urandom_range(LIVE_SET - 1));
    endfunction

    // a step must never read a target that was never written: fill open lanes first
    task automatic run_step();
        int n;
        n = live_count();
        for (int src = 0; src < n; src++)
            if (amp_vec[src] != 0)
                for (int k = 0; k < NLANE; k++)
                    if (!branch_set[src*NLANE+k])
                        send_request(sfp_pkg::OP_WR_BRANCH, 8'(src), 4'(k), pick_live(),
                                     8'($urandom), '0);
        send_request(sfp_pkg::OP_STEP, 8'($urandom), 4'($urandom), 8'($urandom),
                     8'($urandom), $urandom);
    endtask

    task automatic test_basic_ops();
        send_request(sfp_pkg::OP_RD_AMP, 8'd0, 4'd0, 8'd0, 8'd0, '0);
        send_request(sfp_pkg::OP_WR_AMP, 8'd0, 4'd0, 8'd0, 8'd0, 32'h0001_0000);
        send_request(sfp_pkg::OP_WR_AMP, 8'd255, 4'd15, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_request(sfp_pkg::OP_RD_AMP, 8'd255, 4'd0, 8'd0, 8'd0, '0);
        send_request(sfp_pkg::OP_WR_AMP, 8'd255, 4'd0, 8'd0, 8'd0, '0);
        send_request(sfp_pkg::OP_WR_BRANCH, 8'd0, 4'd0, 8'd1, 8'd255, '0);
        send_request(sfp_pkg::OP_WR_BRANCH, 8'd0, 4'd15, 8'd3, 8'd128, '0);
        run_step();
        send_request(sfp_pkg::OP_RD_AMP, 8'd1, 4'd0, 8'd0, 8'd0, '0);
        send_request(sfp_pkg::OP_RD_AMP, 8'd0, 4'd0, 8'd0, 8'd0, '0);
    endtask

    task automatic test_saturation();
        send_request(sfp_pkg::OP_WR_AMP, 8'd2, 4'd0, 8'd0, 8'd0, 32'hFFFF_FFFF);
        send_request(sfp_pkg::OP_WR_AMP, 8'd3, 4'd0, 8'd0, 8'd0, 32'hFFFF_FFFF);
        send_request(sfp_pkg::OP_WR_BRANCH, 8'd2, 4'd0, 8'd1, 8'd255, '0);
        send_request(sfp_pkg::OP_WR_BRANCH, 8'd3, 4'd0, 8'd1, 8'd255, '0);
        run_step();
        send_request(sfp_pkg::OP_RD_AMP, 8'd1, 4'd0, 8'd0, 8'd0, '0);
    endtask

    task automatic test_count_extremes();
        // zero count rejects every access, oversize count clamps
        write_active_count(9'd0);
        send_request(sfp_pkg::OP_WR_AMP, 8'd0, 4'd0, 8'd0, 8'd0, 32'h1234_5678);
        run_step();
        write_active_count(9'd1);
        send_request(sfp_pkg::OP_RD_AMP, 8'd1, 4'd0, 8'd0, 8'd0, '0);
        send_request(sfp_pkg::OP_WR_AMP, 8'd0, 4'd0, 8'd0, 8'd0, 32'h0003_0000);
        run_step();
        send_request(sfp_pkg::OP_RD_AMP, 8'd0, 4'd0, 8'd0, 8'd0, '0);
        write_active_count(9'd511);
        send_request(sfp_pkg::OP_RD_AMP, 8'd255, 4'd0, 8'd0, 8'd0, '0);
    endtask

    task automatic test_random_mix(int idle_pct, int stall_pct, logic [8:0] count, int items);
        int         sel;
        logic [7:0] cpt;
        write_active_count(count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < items; i++) begin
            sel = $urandom_range(99);
            if (sel < 35) begin
                send_request(sfp_pkg::OP_WR_BRANCH, pick_concept(), 4'($urandom), pick_live(),
                             8'($urandom), $urandom);
            end else if (sel < 60) begin
                cpt = pick_concept();
                send_request(sfp_pkg::OP_WR_AMP, cpt, 4'($urandom), 8'($urandom),
                             8'($urandom),
                             (cpt >= LIVE_SET) ? 32'd0 :
                             (($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom));
            end else if (sel < 90) begin
                send_request(sfp_pkg::OP_RD_AMP, pick_concept(), 4'($urandom), 8'($urandom),
                             8'($urandom), $urandom);
            end else begin
                run_step();
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    always @(negedge i_clk)
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        t_outcome exp_r;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: %h", o_m_axis_tdata);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_m_axis_tdata[31:0] !== exp_r.amp) begin
                    $error("amplitude_out expected %h got %h", exp_r.amp, o_m_axis_tdata[31:0]);
                    error_count++;
                end
                if (o_m_axis_tdata[32] !== exp_r.status) begin
                    $error("status expected %b got %b", exp_r.status, o_m_axis_tdata[32]);
                    error_count++;
                end
                if (o_m_axis_tdata[33] !== exp_r.sat) begin
                    $error("saturated expected %b got %b", exp_r.sat, o_m_axis_tdata[33]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        foreach (branch_dst[i]) begin
            branch_dst[i] = '0;
            branch_wgt[i] = '0;
            branch_set[i] = 1'b0;
        end
        foreach (amp_vec[i]) amp_vec[i] = '0;
        active_cnt = sfp_pkg::CFG_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_active_count(9'd256);
        test_basic_ops();
        test_saturation();
        test_count_extremes();
        test_random_mix(0, 0, 9'd16, 15);
        test_random_mix(63, 0, 9'd8, 15);
        test_random_mix(0, 63, 9'd256, 15);
        test_random_mix(27, 27, 9'd20, 15);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
